[hdl/whlu_pkg.sv]
`default_nettype none
package whlu_pkg;

    localparam int IDX_W    = 10;
    localparam int IDX_SPAN = 1024;
    localparam int WGT_W    = 16;
    localparam int SCORE_W  = 16;
    localparam int MARGIN_W = 15;
    localparam int SCALE_W  = 16;
    localparam int GRAD_W   = 32;
    localparam int ACC_W    = 48;
    localparam int CNT_W    = 17;
    localparam int CNT_LIMIT = 131071;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 136;

    localparam logic [WGT_W-1:0] ONE_Q88 = 16'd256;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_SCORE = 1'b1;

    localparam logic NORM_L1 = 1'b0;
    localparam logic NORM_L2 = 1'b1;

    typedef enum logic [1:0] {
        WSRC_ONE    = 2'd0,
        WSRC_DIRECT = 2'd1,
        WSRC_TABLE  = 2'd2
    } whlu_wsrc_t;

    typedef enum logic [1:0] {
        CFG_MARGIN     = 2'd0,
        CFG_NORM_MODE  = 2'd1,
        CFG_WEIGHT_SRC = 2'd2,
        CFG_GRAD_SCALE = 2'd3
    } whlu_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_DIV,
        ST_FIN
    } whlu_state_t;

endpackage
`default_nettype wire

[hdl/whlu_div.sv]
`default_nettype none
module whlu_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [whlu_pkg::ACC_W-1:0]  dividend,
    input  wire logic [whlu_pkg::CNT_W-1:0]  divisor,
    output logic                             done,
    output logic [whlu_pkg::ACC_W-1:0]       quotient
);

    localparam int CW = $clog2(whlu_pkg::ACC_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(whlu_pkg::ACC_W - 1);

    logic [whlu_pkg::ACC_W-1:0] q_reg;
    logic [whlu_pkg::CNT_W-1:0] rem_reg;
    logic [whlu_pkg::CNT_W-1:0] div_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [whlu_pkg::CNT_W:0]   rem_sh;
    logic [whlu_pkg::CNT_W:0]   rem_sub;
    logic                       ge;

    always_comb begin
        rem_sh  = {rem_reg, q_reg[whlu_pkg::ACC_W-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_sub = rem_sh - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[whlu_pkg::ACC_W-2:0], ge};
            rem_reg <= ge ? rem_sub[whlu_pkg::CNT_W-1:0] : rem_sh[whlu_pkg::CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

[hdl/weighted_hinge_loss_unit_core.sv]
`default_nettype none
// Weighted hinge loss unit.
// s_ channel: one word per item. s_tuser selects load (0) or score (1).
// A load word writes weight_value into the weight table at item_index
// (if below TABLE_DEPTH) and gives no result. A score word gives one
// m_ word with the saturated gradients and the running violation count;
// m_tlast marks the batch end, where m_tdata also carries the mean loss.
// A score word passes through hinge and weight select, two multiply
// stages, accumulate and output load. The next word is accepted in the
// cycle after the output load; no new word is taken while a score word
// is in flight. A batch-end word also waits for the bit-serial mean divider.
// cfg_ channel writes the four control registers; it is always ready and
// is meant to be written only while the block is idle.
// After reset the weight table is swept to zero, one entry per cycle over
// min(TABLE_DEPTH, 1024) entries; s_tready stays low until the sweep ends.
// The result sits in an output register; the next word is accepted while
// it waits. If m_tready is held low, the following score word stalls in
// its last stage until the output register is free.
module weighted_hinge_loss_unit_core #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int MAX_ELEMENTS = 65536
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // item_index[9:0], weight_value[25:10], true_score[41:26],
    // bogus_score[57:42], zero fill
    input  wire logic [whlu_pkg::S_DATA_W-1:0]   s_tdata,
    // mode
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // grad_bogus[31:0], grad_true[63:32], loss_value[111:64],
    // violation_count[128:112], zero fill
    output logic [whlu_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [whlu_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int MEM_DEPTH = (TABLE_DEPTH < whlu_pkg::IDX_SPAN) ? TABLE_DEPTH
                                                                 : whlu_pkg::IDX_SPAN;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);
    localparam int CAP = (MAX_ELEMENTS < whlu_pkg::CNT_LIMIT) ? MAX_ELEMENTS
                                                             : whlu_pkg::CNT_LIMIT;
    localparam logic [whlu_pkg::CNT_W-1:0] CNT_CAP = whlu_pkg::CNT_W'(CAP);

    localparam int ACC_W = whlu_pkg::ACC_W;
    localparam int CNT_W = whlu_pkg::CNT_W;
    localparam int GW    = 34;

    // config
    logic [whlu_pkg::MARGIN_W-1:0] margin_reg;
    logic                          norm_mode_reg;
    logic [1:0]                    wsrc_reg;
    logic [whlu_pkg::SCALE_W-1:0]  scale_reg;

    // input fields
    logic [whlu_pkg::IDX_W-1:0]    in_idx;
    logic [whlu_pkg::WGT_W-1:0]    in_wv;
    logic [whlu_pkg::SCORE_W-1:0]  in_ts;
    logic [whlu_pkg::SCORE_W-1:0]  in_bs;
    logic                          in_ok;

    whlu_pkg::whlu_state_t state_reg, state_next;

    logic [AW-1:0]                 clr_addr_reg;
    logic [whlu_pkg::WGT_W-1:0]    weight_mem [MEM_DEPTH];
    logic [whlu_pkg::WGT_W-1:0]    rd_data_reg;
    logic                          mem_we;
    logic [AW-1:0]                 mem_wa;
    logic [whlu_pkg::WGT_W-1:0]    mem_wd;

    logic                          s_accept;
    logic                          out_free;
    logic                          out_load;
    logic                          div_start;
    logic                          div_done;
    logic [ACC_W-1:0]              div_q;

    // stage registers
    logic                          idx_ok_reg;
    logic [whlu_pkg::WGT_W-1:0]    wv_reg;
    logic signed [whlu_pkg::SCORE_W-1:0] ts_reg;
    logic signed [whlu_pkg::SCORE_W-1:0] bs_reg;
    logic                          last_reg;
    logic [whlu_pkg::WGT_W-1:0]    w_reg;
    logic [16:0]                   h_reg;
    logic                          neg_reg;
    logic [32:0]                   wh_reg;
    logic [31:0]                   wg_reg;
    logic [48:0]                   whg_reg;
    logic [49:0]                   whh_reg;

    // batch state
    logic [ACC_W-1:0]              acc_reg;
    logic [CNT_W-1:0]              elem_cnt_reg;
    logic [CNT_W-1:0]              viol_cnt_reg;

    // result holding
    logic [whlu_pkg::GRAD_W-1:0]   res_gb_reg;
    logic [whlu_pkg::GRAD_W-1:0]   res_gt_reg;
    logic [CNT_W-1:0]              res_viol_reg;
    logic                          res_last_reg;

    logic                          m_valid_reg;
    logic [whlu_pkg::GRAD_W-1:0]   m_gb_reg;
    logic [whlu_pkg::GRAD_W-1:0]   m_gt_reg;
    logic [ACC_W-1:0]              m_loss_reg;
    logic [CNT_W-1:0]              m_viol_reg;
    logic                          m_last_reg;

    // combinational datapath
    logic signed [16:0]            d_val;
    logic signed [17:0]            hs_val;
    logic [16:0]                   h_val;
    logic [whlu_pkg::WGT_W-1:0]    w_val;
    logic [GW-1:0]                 gfull;
    logic [GW-1:0]                 gneg;
    logic [ACC_W-1:0]              term;
    logic [ACC_W:0]                acc_sum;
    logic [ACC_W-1:0]              acc_new;
    logic [CNT_W-1:0]              elem_new;
    logic [CNT_W-1:0]              viol_new;
    logic [whlu_pkg::GRAD_W-1:0]   gb_val;
    logic [whlu_pkg::GRAD_W-1:0]   gt_val;

    assign in_idx = s_tdata[9:0];
    assign in_wv  = s_tdata[25:10];
    assign in_ts  = s_tdata[41:26];
    assign in_bs  = s_tdata[57:42];
    assign in_ok  = 32'(in_idx) < 32'(TABLE_DEPTH);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg    <= whlu_pkg::MARGIN_W'(256);
            norm_mode_reg <= whlu_pkg::NORM_L1;
            wsrc_reg      <= whlu_pkg::WSRC_ONE;
            scale_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                whlu_pkg::CFG_MARGIN:     margin_reg    <= cfg_data[whlu_pkg::MARGIN_W-1:0];
                whlu_pkg::CFG_NORM_MODE:  norm_mode_reg <= cfg_data[0];
                whlu_pkg::CFG_WEIGHT_SRC: wsrc_reg      <= cfg_data[1:0];
                whlu_pkg::CFG_GRAD_SCALE: scale_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            whlu_pkg::ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) state_next = whlu_pkg::ST_IDLE;
            end
            whlu_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == whlu_pkg::MODE_SCORE) state_next = whlu_pkg::ST_READ;
            end
            whlu_pkg::ST_READ: state_next = whlu_pkg::ST_MUL1;
            whlu_pkg::ST_MUL1: state_next = whlu_pkg::ST_MUL2;
            whlu_pkg::ST_MUL2: state_next = whlu_pkg::ST_ACC;
            whlu_pkg::ST_ACC: begin
                div_start  = last_reg;
                state_next = last_reg ? whlu_pkg::ST_DIV : whlu_pkg::ST_FIN;
            end
            whlu_pkg::ST_DIV: begin
                if (div_done) state_next = whlu_pkg::ST_FIN;
            end
            whlu_pkg::ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = whlu_pkg::ST_IDLE;
                end
            end
            default: state_next = whlu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= whlu_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == whlu_pkg::ST_CLEAR) clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // weight table
    always_comb begin
        if (state_reg == whlu_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end else begin
            mem_we = s_accept && s_tuser == whlu_pkg::MODE_LOAD && in_ok;
            mem_wa = in_idx[AW-1:0];
            mem_wd = in_wv;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) weight_mem[mem_wa] <= mem_wd;
        rd_data_reg <= weight_mem[in_idx[AW-1:0]];
    end

    // hinge and weight select
    always_comb begin
        d_val  = 17'(ts_reg) - 17'(bs_reg);
        hs_val = $signed({3'b000, margin_reg}) - 18'(d_val);
        h_val  = (hs_val > 18'sd0) ? hs_val[16:0] : '0;
        unique case (wsrc_reg)
            whlu_pkg::WSRC_DIRECT: w_val = wv_reg;
            whlu_pkg::WSRC_TABLE:  w_val = idx_ok_reg ? rd_data_reg : '0;
            default:               w_val = whlu_pkg::ONE_Q88;
        endcase
    end

    // gradient and accumulate
    always_comb begin
        if (norm_mode_reg == whlu_pkg::NORM_L1) begin
            gfull = (h_reg != '0) ? {10'd0, wg_reg[31:8]} : '0;
            term  = {15'd0, wh_reg};
        end else begin
            gfull = whg_reg[48:15];
            term  = (whh_reg[49:48] != 2'b00) ? {ACC_W{1'b1}} : whh_reg[47:0];
        end
        gneg    = ~gfull + GW'(1);
        gb_val  = (gfull > GW'(34'h07FFFFFFF)) ? 32'h7FFFFFFF : gfull[31:0];
        gt_val  = (gfull > GW'(34'h080000000)) ? 32'h80000000 : gneg[31:0];
        acc_sum = {1'b0, acc_reg} + {1'b0, term};
        acc_new = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        elem_new = (elem_cnt_reg < CNT_CAP) ? elem_cnt_reg + CNT_W'(1) : elem_cnt_reg;
        viol_new = (neg_reg && viol_cnt_reg < CNT_CAP) ? viol_cnt_reg + CNT_W'(1)
                                                       : viol_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            idx_ok_reg <= in_ok;
            wv_reg     <= in_wv;
            ts_reg     <= in_ts;
            bs_reg     <= in_bs;
            last_reg   <= s_tlast;
        end
        if (state_reg == whlu_pkg::ST_READ) begin
            w_reg   <= w_val;
            h_reg   <= h_val;
            neg_reg <= d_val < 17'sd0;
        end
        if (state_reg == whlu_pkg::ST_MUL1) begin
            wh_reg <= 33'(w_reg) * 33'(h_reg);
            wg_reg <= 32'(w_reg) * 32'(scale_reg);
        end
        if (state_reg == whlu_pkg::ST_MUL2) begin
            whg_reg <= 49'(wh_reg) * 49'(scale_reg);
            whh_reg <= 50'(wh_reg) * 50'(h_reg);
        end
        if (state_reg == whlu_pkg::ST_ACC) begin
            res_gb_reg   <= gb_val;
            res_gt_reg   <= gt_val;
            res_viol_reg <= viol_new;
            res_last_reg <= last_reg;
        end
        if (out_load) begin
            m_gb_reg   <= res_gb_reg;
            m_gt_reg   <= res_gt_reg;
            m_loss_reg <= res_last_reg ? div_q : '0;
            m_viol_reg <= res_viol_reg;
            m_last_reg <= res_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            elem_cnt_reg <= '0;
            viol_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (state_reg == whlu_pkg::ST_ACC) begin
                acc_reg      <= last_reg ? '0 : acc_new;
                elem_cnt_reg <= last_reg ? '0 : elem_new;
                viol_cnt_reg <= last_reg ? '0 : viol_new;
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    whlu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_new),
        .divisor  (elem_new),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'd0, m_viol_reg, m_loss_reg, m_gt_reg, m_gb_reg};

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
module testbench;

    localparam int TB_TABLE_DEPTH  = 1024;
    localparam int TB_MAX_ELEMENTS = 65536;
    localparam int COUNT_CAP = (TB_MAX_ELEMENTS < whlu_pkg::CNT_LIMIT) ? TB_MAX_ELEMENTS
                                                                      : whlu_pkg::CNT_LIMIT;
    localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;
    localparam logic [1:0] WSRC_SPARE = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [9:0]  idx;
        logic [15:0] wgt;
        logic [15:0] t_score;
        logic [15:0] b_score;
        logic        last;
    } hinge_word_t;

    typedef struct packed {
        logic [31:0] g_bogus;
        logic [31:0] g_true;
        logic [47:0] loss;
        logic [16:0] viol;
        logic        done;
    } grad_word_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [whlu_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [whlu_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index = '0;
    logic [whlu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // model of the block
    logic [whlu_pkg::WGT_W-1:0]    wtab [0:whlu_pkg::IDX_SPAN-1];
    longint unsigned               loss_sum = 0;
    int                            elem_cnt = 0;
    int                            viol_cnt = 0;
    logic [whlu_pkg::MARGIN_W-1:0] hinge_margin = 15'd256;
    logic                          loss_norm = whlu_pkg::NORM_L1;
    logic [1:0]                    weight_sel = whlu_pkg::WSRC_ONE;
    logic [whlu_pkg::SCALE_W-1:0]  grad_scale = '0;

    hinge_word_t pending[$];
    grad_word_t  results_due[$];
    hinge_word_t cur_word;

    int  words_issued = 0;
    int  words_taken = 0;
    int  words_checked = 0;
    int  batch_ends = 0;
    int  reg_settings = 0;
    int  errors = 0;
    int  hold_off = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    weighted_hinge_loss_unit_core #(
        .TABLE_DEPTH (TB_TABLE_DEPTH),
        .MAX_ELEMENTS(TB_MAX_ELEMENTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Update the model with one accepted word and queue the gradient word it causes
    task automatic take_word(hinge_word_t wd);
        int              ts_i;
        int              bs_i;
        int              diff;
        longint          hinge_s;
        longint unsigned hinge;
        longint unsigned wt;
        longint unsigned g_full;
        longint unsigned g_neg;
        longint unsigned term;
        grad_word_t      res;
        if (wd.mode == whlu_pkg::MODE_LOAD) begin
            if (int'(wd.idx) < TB_TABLE_DEPTH) wtab[wd.idx] = wd.wgt;
        end else begin
            ts_i = $signed(wd.t_score);
            bs_i = $signed(wd.b_score);
            diff = ts_i - bs_i;
            hinge_s = longint'(hinge_margin) - longint'(diff);
            hinge = (hinge_s > 0) ? hinge_s : 0;
            case (weight_sel)
                whlu_pkg::WSRC_DIRECT: wt = wd.wgt;
                whlu_pkg::WSRC_TABLE:  wt = (int'(wd.idx) < TB_TABLE_DEPTH) ? wtab[wd.idx] : 0;
                default:               wt = whlu_pkg::ONE_Q88;
            endcase
            if (loss_norm == whlu_pkg::NORM_L1) begin
                g_full = (hinge != 0) ? ((wt * grad_scale) >> 8) : 0;
                term = wt * hinge;
            end else begin
                g_full = (64'd2 * wt * hinge * grad_scale) >> 16;
                term = wt * hinge * hinge;
            end
            if (term > SUM_MAX) term = SUM_MAX;
            g_neg = 64'd0 - g_full;
            res.g_bogus = (g_full > 64'd2147483647) ? 32'h7FFF_FFFF : g_full[31:0];
            res.g_true = (g_full > 64'd2147483648) ? 32'h8000_0000 : g_neg[31:0];
            loss_sum = loss_sum + term;
            if (loss_sum > SUM_MAX) loss_sum = SUM_MAX;
            if (elem_cnt < COUNT_CAP) elem_cnt++;
            if (diff < 0 && viol_cnt < COUNT_CAP) viol_cnt++;
            res.viol = viol_cnt[16:0];
            res.done = wd.last;
            res.loss = '0;
            if (wd.last) begin
                if (elem_cnt != 0) res.loss = 48'(loss_sum / longint'(elem_cnt));
                loss_sum = 0;
                elem_cnt = 0;
                viol_cnt = 0;
                batch_ends++;
            end
            results_due.push_back(res);
        end
    endtask

    task automatic check_word();
        grad_word_t want;
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("result word with nothing outstanding, tdata %h", m_tdata));
        end else begin
            want = results_due.pop_front();
            words_checked++;
            if (m_tdata[31:0] !== want.g_bogus)
                report_mismatch($sformatf("grad_bogus got %0d want %0d",
                    $signed(m_tdata[31:0]), $signed(want.g_bogus)));
            if (m_tdata[63:32] !== want.g_true)
                report_mismatch($sformatf("grad_true got %0d want %0d",
                    $signed(m_tdata[63:32]), $signed(want.g_true)));
            if (m_tdata[111:64] !== want.loss)
                report_mismatch($sformatf("loss_value got %0d want %0d",
                    m_tdata[111:64], want.loss));
            if (m_tdata[128:112] !== want.viol)
                report_mismatch($sformatf("violation_count got %0d want %0d",
                    m_tdata[128:112], want.viol));
            if (m_tlast !== want.done)
                report_mismatch($sformatf("batch_done got %b want %b", m_tlast, want.done));
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            hold_off = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_word(cur_word);
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (hold_off > 0) begin
                    hold_off--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0) begin
                    cur_word = pending.pop_front();
                    s_tdata <= {6'd0, cur_word.b_score, cur_word.t_score,
                                cur_word.wgt, cur_word.idx};
                    s_tuser <= cur_word.mode;
                    s_tlast <= cur_word.last;
                    s_tvalid <= 1'b1;
                    hold_off = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) check_word();
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // keeps cfg_valid high across the write; the caller lowers it
    task automatic write_reg(whlu_pkg::whlu_cfg_idx_t ri,
                             logic [whlu_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (ri)
            whlu_pkg::CFG_MARGIN:     hinge_margin = val[whlu_pkg::MARGIN_W-1:0];
            whlu_pkg::CFG_NORM_MODE:  loss_norm = val[0];
            whlu_pkg::CFG_WEIGHT_SRC: weight_sel = val[1:0];
            whlu_pkg::CFG_GRAD_SCALE: grad_scale = val;
        endcase
    endtask

    task automatic program_regs(logic [whlu_pkg::MARGIN_W-1:0] mg, logic nm, logic [1:0] ws,
                                logic [whlu_pkg::SCALE_W-1:0] sc);
        write_reg(whlu_pkg::CFG_MARGIN, {1'b0, mg});
        write_reg(whlu_pkg::CFG_NORM_MODE, {15'd0, nm});
        write_reg(whlu_pkg::CFG_WEIGHT_SRC, {14'd0, ws});
        write_reg(whlu_pkg::CFG_GRAD_SCALE, sc);
        cfg_valid <= 1'b0;
        reg_settings++;
    endtask

    task automatic queue_word(logic md, int idx, int wgt, int ts, int bs, logic lst);
        hinge_word_t wd;
        wd.mode = md;
        wd.idx = idx[9:0];
        wd.wgt = wgt[15:0];
        wd.t_score = ts[15:0];
        wd.b_score = bs[15:0];
        wd.last = lst;
        pending.push_back(wd);
        words_issued++;
    endtask

    task automatic settle();
        while (words_taken < words_issued || results_due.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic queue_random(logic [whlu_pkg::MARGIN_W-1:0] mg, int count);
        int  r;
        int  idx;
        int  wgt;
        int  ts;
        int  bs;
        logic md;
        for (int k = 0; k < count; k++) begin
            md = ($urandom_range(0, 3) == 0) ? whlu_pkg::MODE_LOAD : whlu_pkg::MODE_SCORE;
            r = $urandom_range(0, 99);
            if (r < 85) idx = $urandom_range(0, 63);
            else if (r < 95) idx = $urandom_range(0, whlu_pkg::IDX_SPAN - 1);
            else idx = $urandom_range(whlu_pkg::IDX_SPAN - 24, whlu_pkg::IDX_SPAN - 1);
            r = $urandom_range(0, 99);
            if (r < 10) wgt = 16'hFFFF;
            else if (r < 20) wgt = 0;
            else if (r < 40) wgt = whlu_pkg::ONE_Q88;
            else wgt = $urandom_range(0, 65535);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                ts = int'($urandom_range(0, 65535)) - 32768;
                bs = int'($urandom_range(0, 65535)) - 32768;
            end else if (r < 80) begin
                // difference close to the margin
                ts = int'($urandom_range(0, 65535)) - 32768;
                bs = ts - int'(mg) + int'($urandom_range(0, 16)) - 8;
                if (bs < -32768) bs = -32768;
                if (bs > 32767) bs = 32767;
            end else begin
                ts = int'($urandom_range(0, 1023)) - 512;
                bs = int'($urandom_range(0, 1023)) - 512;
            end
            queue_word(md, idx, wgt, ts, bs, $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        logic [whlu_pkg::MARGIN_W-1:0] mg;
        logic [whlu_pkg::SCALE_W-1:0]  sc;
        int                            r;
        int                            ts;
        for (int k = 0; k < whlu_pkg::IDX_SPAN; k++) wtab[k] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // table lookups: unloaded entry, top entry, extremes
        program_regs(15'd256, whlu_pkg::NORM_L1, whlu_pkg::WSRC_TABLE, 16'hFFFF);
        queue_word(whlu_pkg::MODE_SCORE, 5, 0, 0, 0, 1'b0);
        queue_word(whlu_pkg::MODE_LOAD, 0, 16'hFFFF, 0, 0, 1'b0);
        queue_word(whlu_pkg::MODE_LOAD, 1023, 16'h1234, 0, 0, 1'b0);
        queue_word(whlu_pkg::MODE_LOAD, 999, 16'h0100, 0, 0, 1'b0);
        queue_word(whlu_pkg::MODE_LOAD, 1, 16'h8000, 0, 0, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 0, 0, -32768, 32767, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 1023, 0, 32767, -32768, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 999, 0, 100, 100, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 1, 0, 0, 1, 1'b1);
        settle();

        // L2 with saturating terms, gradients and accumulator
        program_regs(15'h7FFF, whlu_pkg::NORM_L2, whlu_pkg::WSRC_DIRECT, 16'hFFFF);
        queue_word(whlu_pkg::MODE_SCORE, 0, 16'hFFFF, -32768, 32767, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 0, 16'hFFFF, -32768, 32767, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 0, 0, 5, 3, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 0, 1, 32767, -32768, 1'b1);
        settle();

        // spare weight source acts as unweighted; zero margin
        program_regs(15'd0, whlu_pkg::NORM_L1, WSRC_SPARE, 16'd1);
        queue_word(whlu_pkg::MODE_SCORE, 3, 16'hFFFF, 7, 7, 1'b0);
        queue_word(whlu_pkg::MODE_SCORE, 3, 0, 0, 1, 1'b0);
        queue_word(whlu_pkg::MODE_LOAD, 2, 16'h1234, 0, 0, 1'b1);
        queue_word(whlu_pkg::MODE_SCORE, 2, 0, -1, 0, 1'b1);
        settle();

        // one long batch of violations, back to back
        no_idle = 1'b1;
        program_regs(15'd256, whlu_pkg::NORM_L1, whlu_pkg::WSRC_ONE, 16'h1000);
        for (int k = 0; k < 112; k++) begin
            ts = -int'($urandom_range(0, 32768));
            queue_word(whlu_pkg::MODE_SCORE, $urandom_range(0, whlu_pkg::IDX_SPAN - 1),
                       $urandom_range(0, 65535),
                       ts, ts + int'($urandom_range(1, 32767)),
                       k == 111);
        end
        settle();

        for (int ph = 0; ph < 7; ph++) begin
            no_idle = (ph == 2);
            r = $urandom_range(0, 3);
            mg = (r == 0) ? 15'd0 : (r == 1) ? 15'h7FFF :
                 (r == 2) ? 15'd256 : 15'($urandom_range(0, 2048));
            r = $urandom_range(0, 2);
            sc = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
            program_regs(mg, 1'($urandom_range(0, 1)), 2'(ph % 4), sc);
            queue_random(mg, 100);
            settle();
        end

        $display("Sent %0d input words over %0d register settings; %0d batch ends seen",
                 words_issued, reg_settings, batch_ends);
        $display("Checked %0d gradient words, %0d mismatches", words_checked, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Timeout: %0d of %0d words taken, %0d results outstanding",
                 words_taken, words_issued, results_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
